// ===== rtl/core/scp_pkg.sv =====
package scp_pkg;

  localparam int LIMB_BITS = 32;
  localparam int MU_BITS = 64;
  localparam int MU_FRAC = 32;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 64;
  localparam int LEPS_W = 32;
  localparam int DEPS_W = 63;

  localparam logic [LEPS_W-1:0] LEPS_RESET = 32'd4;
  localparam logic [DEPS_W-1:0] DEPS_RESET = 63'd18446744074;

  // register index, taken from the 8-byte aligned address
  localparam logic REG_LEN_EPS = 1'b0;
  localparam logic REG_DEN_EPS = 1'b1;

  localparam logic [2:0] ST_INSIDE = 3'd0;
  localparam logic [2:0] ST_B_DEGEN = 3'd1;
  localparam logic [2:0] ST_A_DEGEN = 3'd2;
  localparam logic [2:0] ST_PARALLEL = 3'd3;
  localparam logic [2:0] ST_OUTSIDE = 3'd4;

  typedef struct packed {
    logic signed [31:0] a_start_x;
    logic signed [31:0] a_start_y;
    logic signed [31:0] a_start_z;
    logic signed [31:0] a_end_x;
    logic signed [31:0] a_end_y;
    logic signed [31:0] a_end_z;
    logic signed [31:0] b_start_x;
    logic signed [31:0] b_start_y;
    logic signed [31:0] b_start_z;
    logic signed [31:0] b_end_x;
    logic signed [31:0] b_end_y;
    logic signed [31:0] b_end_z;
  } scp_in_t;

  typedef struct packed {
    logic signed [31:0] near_a_x;
    logic signed [31:0] near_a_y;
    logic signed [31:0] near_a_z;
    logic signed [31:0] near_b_x;
    logic signed [31:0] near_b_y;
    logic signed [31:0] near_b_z;
    logic [2:0]         status;
    logic               saturated;
  } scp_out_t;

endpackage

// ===== rtl/core/scp_dly.sv =====
module scp_dly #(
  parameter int W = 8,
  parameter int N = 4
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);
  import scp_pkg::*;

  logic [W-1:0] sr [N];

  always_ff @(posedge clk) begin
    if (en) begin
      sr[0] <= d;
      for (int i = 1; i < N; i++) begin
        sr[i] <= sr[i-1];
      end
    end
  end

  assign q = sr[N-1];

endmodule

// ===== rtl/core/scp_mul.sv =====
module scp_mul #(
  parameter int AW = 68,
  parameter int BW = 68
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] p
);
  import scp_pkg::*;

  localparam int NA = (AW + LIMB_BITS - 1) / LIMB_BITS;
  localparam int NB = (BW + LIMB_BITS - 1) / LIMB_BITS;
  localparam int RW = (NB + 1) * LIMB_BITS;
  localparam int MW = (NA + NB) * LIMB_BITS;
  localparam int OW = AW + BW;

  logic [AW-1:0] abs_a;
  logic [BW-1:0] abs_b;
  logic [NA*LIMB_BITS-1:0] ma;
  logic [NB*LIMB_BITS-1:0] mb;
  logic neg1, neg2, neg3, neg4;
  logic [2*LIMB_BITS-1:0] pp [NA][NB];
  logic [RW-1:0] row [NA];
  logic [RW-1:0] row_next [NA];
  logic [MW-1:0] tot;
  logic [MW-1:0] tot_next;

  always_comb begin
    abs_a = a[AW-1] ? -a : a;
    abs_b = b[BW-1] ? -b : b;
  end

  // partial products of 32-bit limbs, summed per row and then across rows
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_next[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_next[i] = row_next[i] + (RW'(pp[i][j]) << (LIMB_BITS * j));
      end
    end
    tot_next = '0;
    for (int i = 0; i < NA; i++) begin
      tot_next = tot_next + (MW'(row[i]) << (LIMB_BITS * i));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ma <= (NA*LIMB_BITS)'(abs_a);
      mb <= (NB*LIMB_BITS)'(abs_b);
      neg1 <= a[AW-1] ^ b[BW-1];
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp[i][j] <= ma[i*LIMB_BITS +: LIMB_BITS] * mb[j*LIMB_BITS +: LIMB_BITS];
        end
      end
      neg2 <= neg1;
      row <= row_next;
      neg3 <= neg2;
      tot <= tot_next;
      neg4 <= neg3;
      p <= neg4 ? -OW'(tot) : OW'(tot);
    end
  end

endmodule

// ===== rtl/core/scp_div.sv =====
module scp_div #(
  parameter int NW = 169,
  parameter int DW = 137
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [NW-1:0]              num,
  input  logic [DW-1:0]              den,
  output logic [scp_pkg::MU_BITS-1:0] quo,
  output logic                       ovf
);
  import scp_pkg::*;

  localparam int QW = MU_BITS;
  localparam int HW = NW - QW;
  localparam int CW = (HW > DW) ? HW : DW;

  logic [DW-1:0] rem [QW+1];
  logic [DW-1:0] dv  [QW+1];
  logic [QW-1:0] low [QW+1];
  logic [QW-1:0] qt  [QW+1];
  logic          ov  [QW+1];

  // quotient of 2^QW or more means the upper numerator part already reaches den
  always_ff @(posedge clk) begin
    if (en) begin
      ov[0] <= CW'(num[NW-1:QW]) >= CW'(den);
      rem[0] <= DW'(num[NW-1:QW]);
      low[0] <= num[QW-1:0];
      qt[0] <= '0;
      dv[0] <= den;
    end
  end

  for (genvar s = 1; s <= QW; s++) begin : g_step
    logic [DW:0] trial;
    logic        ge;
    always_comb begin
      trial = {rem[s-1], low[s-1][QW-1]};
      ge = trial >= {1'b0, dv[s-1]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[s] <= ge ? DW'(trial - {1'b0, dv[s-1]}) : DW'(trial);
        low[s] <= low[s-1] << 1;
        qt[s] <= {qt[s-1][QW-2:0], ge};
        dv[s] <= dv[s-1];
        ov[s] <= ov[s-1];
      end
    end
  end

  assign quo = qt[QW];
  assign ovf = ov[QW];

endmodule

// ===== rtl/core/segment_closest_points_unit.sv =====
// closest points between two 3d lines, each given by a start and an end point
// input channel: in_valid/in_stall carry one pair of lines per beat (q16.16)
// output channel: out_valid/out_stall carry both closest points, a status code
// and a saturation flag per beat
// one beat is accepted every cycle unless an output beat is stalled, set by
// the fully pipelined dot products, 32-bit limb multipliers and the two
// restoring dividers
// the whole pipeline advances together; while an output beat is stalled the
// pipeline holds and in_stall is high, otherwise bubbles keep moving
// reset clears the valid bits of every stage and loads the epsilon registers
// with their defaults; the thresholds are written through the apb port
// (length epsilon at 0x0, denominator epsilon at 0x8) and read back there
module segment_closest_points_unit #(
  parameter int COORD_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  scp_pkg::scp_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output scp_pkg::scp_out_t             out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [scp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [scp_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [scp_pkg::CFG_DATA_W-1:0] prdata,
  output logic                          pready
);
  import scp_pkg::*;

  localparam int C = COORD_BITS;
  localparam int DFW = C + 1;
  localparam int DPW = 2 * DFW;
  localparam int DW = DPW + 2;
  localparam int PW = 2 * DW + 1;
  localparam int NW = PW + MU_FRAC;
  localparam int PRW = MU_BITS + DFW;
  localparam int PAW = PRW - MU_FRAC + 1;
  localparam int LAT = 83;

  localparam logic signed [PAW-1:0] CMAX = {{(PAW-C+1){1'b0}}, {(C-1){1'b1}}};
  localparam logic signed [PAW-1:0] CMIN = {{(PAW-C+1){1'b1}}, {(C-1){1'b0}}};
  localparam logic signed [MU_BITS-1:0] MU_MAX = {1'b0, {(MU_BITS-1){1'b1}}};
  localparam logic signed [MU_BITS-1:0] MU_MIN = {1'b1, {(MU_BITS-1){1'b0}}};

  logic en;
  logic [LAT:1] vld;
  logic [LEPS_W-1:0] leps;
  logic [DEPS_W-1:0] deps;

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      leps <= LEPS_RESET;
      deps <= DEPS_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[CFG_ADDR_W-1])
        REG_LEN_EPS: leps <= pwdata[LEPS_W-1:0];
        REG_DEN_EPS: deps <= pwdata[DEPS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[CFG_ADDR_W-1])
      REG_LEN_EPS: prdata = CFG_DATA_W'(leps);
      REG_DEN_EPS: prdata = CFG_DATA_W'(deps);
      default: prdata = '0;
    endcase
  end

  // pipeline control
  assign out_valid = vld[LAT];
  assign in_stall = vld[LAT] && out_stall;
  assign en = !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-1:1], in_valid};
    end
  end

  // stage 1: coordinates and direction vectors
  logic signed [C-1:0] pin [12];
  logic signed [C-1:0] p1 [12];
  logic signed [DFW-1:0] d21_1 [3];
  logic signed [DFW-1:0] d43_1 [3];
  logic signed [DFW-1:0] d13_1 [3];

  always_comb begin
    pin[0] = in_data.a_start_x[C-1:0];
    pin[1] = in_data.a_start_y[C-1:0];
    pin[2] = in_data.a_start_z[C-1:0];
    pin[3] = in_data.a_end_x[C-1:0];
    pin[4] = in_data.a_end_y[C-1:0];
    pin[5] = in_data.a_end_z[C-1:0];
    pin[6] = in_data.b_start_x[C-1:0];
    pin[7] = in_data.b_start_y[C-1:0];
    pin[8] = in_data.b_start_z[C-1:0];
    pin[9] = in_data.b_end_x[C-1:0];
    pin[10] = in_data.b_end_y[C-1:0];
    pin[11] = in_data.b_end_z[C-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 12; k++) begin
        p1[k] <= pin[k];
      end
      for (int k = 0; k < 3; k++) begin
        d21_1[k] <= DFW'(pin[3+k]) - DFW'(pin[k]);
        d43_1[k] <= DFW'(pin[9+k]) - DFW'(pin[6+k]);
        d13_1[k] <= DFW'(pin[k]) - DFW'(pin[6+k]);
      end
    end
  end

  // stages 2-3: dot products
  // order: d4343, d2121, d1343, d4321, d1321
  logic signed [DPW-1:0] pr [15];
  logic signed [DW-1:0] dt [5];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        pr[k] <= d43_1[k] * d43_1[k];
        pr[3+k] <= d21_1[k] * d21_1[k];
        pr[6+k] <= d13_1[k] * d43_1[k];
        pr[9+k] <= d43_1[k] * d21_1[k];
        pr[12+k] <= d13_1[k] * d21_1[k];
      end
      for (int i = 0; i < 5; i++) begin
        dt[i] <= DW'(pr[3*i]) + DW'(pr[3*i+1]) + DW'(pr[3*i+2]);
      end
    end
  end

  // stage 4: degenerate checks, bit 1 for line b and bit 0 for line a
  logic [1:0] deg4, deg9, deg10;

  always_ff @(posedge clk) begin
    if (en) begin
      deg4[1] <= DW'($unsigned(dt[0])) < DW'(leps);
      deg4[0] <= DW'($unsigned(dt[1])) < DW'(leps);
    end
  end

  scp_dly #(.W(2), .N(5)) u_dly_deg (.clk(clk), .en(en), .d(deg4), .q(deg9));

  // stages 4-8: second-level products
  logic signed [2*DW-1:0] m [6];

  scp_mul #(.AW(DW), .BW(DW)) u_mul_den0 (.clk(clk), .en(en), .a(dt[1]), .b(dt[0]), .p(m[0]));
  scp_mul #(.AW(DW), .BW(DW)) u_mul_den1 (.clk(clk), .en(en), .a(dt[3]), .b(dt[3]), .p(m[1]));
  scp_mul #(.AW(DW), .BW(DW)) u_mul_na0 (.clk(clk), .en(en), .a(dt[2]), .b(dt[3]), .p(m[2]));
  scp_mul #(.AW(DW), .BW(DW)) u_mul_na1 (.clk(clk), .en(en), .a(dt[4]), .b(dt[0]), .p(m[3]));
  scp_mul #(.AW(DW), .BW(DW)) u_mul_nb0 (.clk(clk), .en(en), .a(dt[2]), .b(dt[1]), .p(m[4]));
  scp_mul #(.AW(DW), .BW(DW)) u_mul_nb1 (.clk(clk), .en(en), .a(dt[4]), .b(dt[3]), .p(m[5]));

  // stages 9-11: denominator, numerators, magnitudes, early status
  logic signed [PW-1:0] den9, na9, nb9;
  logic [PW-1:0] aden10, ana10, anb10;
  logic [1:0] sgn10, sgn75;
  logic [2:0] pre11, pre82;

  always_ff @(posedge clk) begin
    if (en) begin
      den9 <= PW'(m[0]) - PW'(m[1]);
      na9 <= PW'(m[2]) - PW'(m[3]);
      nb9 <= PW'(m[4]) - PW'(m[5]);
      aden10 <= den9[PW-1] ? -den9 : den9;
      ana10 <= na9[PW-1] ? -na9 : na9;
      anb10 <= nb9[PW-1] ? -nb9 : nb9;
      sgn10[1] <= na9[PW-1] ^ den9[PW-1];
      sgn10[0] <= nb9[PW-1] ^ den9[PW-1];
      deg10 <= deg9;
      if (deg10[1]) begin
        pre11 <= ST_B_DEGEN;
      end else if (deg10[0]) begin
        pre11 <= ST_A_DEGEN;
      end else if (aden10 == '0 || aden10 < PW'(deps)) begin
        pre11 <= ST_PARALLEL;
      end else begin
        pre11 <= ST_INSIDE;
      end
    end
  end

  scp_dly #(.W(3), .N(71)) u_dly_pre (.clk(clk), .en(en), .d(pre11), .q(pre82));
  scp_dly #(.W(2), .N(65)) u_dly_sgn (.clk(clk), .en(en), .d(sgn10), .q(sgn75));

  // stages 11-75: ratio magnitudes
  logic [MU_BITS-1:0] qa, qb;
  logic ova, ovb;

  scp_div #(.NW(NW), .DW(PW)) u_div_a (
    .clk(clk), .en(en), .num({ana10, {MU_FRAC{1'b0}}}), .den(aden10), .quo(qa), .ovf(ova)
  );
  scp_div #(.NW(NW), .DW(PW)) u_div_b (
    .clk(clk), .en(en), .num({anb10, {MU_FRAC{1'b0}}}), .den(aden10), .quo(qb), .ovf(ovb)
  );

  // stage 76: signed ratios clamped to 64 bits
  localparam logic [MU_BITS-1:0] NEG_LIMIT = {1'b1, {(MU_BITS-1){1'b0}}};
  logic signed [MU_BITS-1:0] mua76, mub76;
  logic sat76, sat82;
  logic sat_a, sat_b;

  always_comb begin
    sat_a = sgn75[1] ? (ova || qa > NEG_LIMIT) : (ova || qa[MU_BITS-1]);
    sat_b = sgn75[0] ? (ovb || qb > NEG_LIMIT) : (ovb || qb[MU_BITS-1]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (sat_a) begin
        mua76 <= sgn75[1] ? MU_MIN : MU_MAX;
      end else begin
        mua76 <= sgn75[1] ? -qa : qa;
      end
      if (sat_b) begin
        mub76 <= sgn75[0] ? MU_MIN : MU_MAX;
      end else begin
        mub76 <= sgn75[0] ? -qb : qb;
      end
      sat76 <= sat_a || sat_b;
    end
  end

  scp_dly #(.W(1), .N(6)) u_dly_sat (.clk(clk), .en(en), .d(sat76), .q(sat82));

  // direction vectors carried to the point multipliers
  logic [6*DFW-1:0] dir1, dir76;
  logic signed [DFW-1:0] d21_76 [3];
  logic signed [DFW-1:0] d43_76 [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dir1[k*DFW +: DFW] = d21_1[k];
      dir1[(3+k)*DFW +: DFW] = d43_1[k];
      d21_76[k] = dir76[k*DFW +: DFW];
      d43_76[k] = dir76[(3+k)*DFW +: DFW];
    end
  end

  scp_dly #(.W(6*DFW), .N(75)) u_dly_dir (.clk(clk), .en(en), .d(dir1), .q(dir76));

  // stages 77-81: offsets along each line
  logic signed [PRW-1:0] ofa [3];
  logic signed [PRW-1:0] ofb [3];

  for (genvar k = 0; k < 3; k++) begin : g_pt
    scp_mul #(.AW(MU_BITS), .BW(DFW)) u_mul_a (
      .clk(clk), .en(en), .a(mua76), .b(d21_76[k]), .p(ofa[k])
    );
    scp_mul #(.AW(MU_BITS), .BW(DFW)) u_mul_b (
      .clk(clk), .en(en), .a(mub76), .b(d43_76[k]), .p(ofb[k])
    );
  end

  // coordinates carried to the final stages
  logic [12*C-1:0] pts1, pts81;
  logic signed [C-1:0] p81 [12];
  logic signed [C-1:0] p82 [12];

  always_comb begin
    for (int k = 0; k < 12; k++) begin
      pts1[k*C +: C] = p1[k];
      p81[k] = pts81[k*C +: C];
    end
  end

  scp_dly #(.W(12*C), .N(80)) u_dly_pts (.clk(clk), .en(en), .d(pts1), .q(pts81));

  // stage 82: unsaturated points
  logic signed [PAW-1:0] pa82 [3];
  logic signed [PAW-1:0] pb82 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 12; k++) begin
        p82[k] <= p81[k];
      end
      for (int k = 0; k < 3; k++) begin
        pa82[k] <= PAW'(p81[k]) + PAW'(ofa[k] >>> MU_FRAC);
        pb82[k] <= PAW'(p81[6+k]) + PAW'(ofb[k] >>> MU_FRAC);
      end
    end
  end

  // stage 83: box test, clamp and status
  logic signed [PAW-1:0] pt [6];
  logic signed [PAW-1:0] bs [6];
  logic signed [PAW-1:0] be [6];
  logic signed [PAW-1:0] lo, hi;
  logic signed [C-1:0] cl [6];
  logic in_box, csat;
  scp_out_t res;

  always_comb begin
    in_box = 1'b1;
    csat = 1'b0;
    for (int k = 0; k < 3; k++) begin
      pt[k] = pa82[k];
      pt[3+k] = pb82[k];
      bs[k] = PAW'(p82[k]);
      be[k] = PAW'(p82[3+k]);
      bs[3+k] = PAW'(p82[6+k]);
      be[3+k] = PAW'(p82[9+k]);
    end
    lo = '0;
    hi = '0;
    for (int k = 0; k < 6; k++) begin
      lo = (bs[k] <= be[k]) ? bs[k] : be[k];
      hi = (bs[k] <= be[k]) ? be[k] : bs[k];
      if (pt[k] < lo || pt[k] > hi) begin
        in_box = 1'b0;
      end
      if (pt[k] < CMIN) begin
        cl[k] = CMIN[C-1:0];
        csat = 1'b1;
      end else if (pt[k] > CMAX) begin
        cl[k] = CMAX[C-1:0];
        csat = 1'b1;
      end else begin
        cl[k] = pt[k][C-1:0];
      end
    end
    if (pre82 != ST_INSIDE) begin
      res = '0;
      res.status = pre82;
    end else begin
      res.near_a_x = 32'(cl[0]);
      res.near_a_y = 32'(cl[1]);
      res.near_a_z = 32'(cl[2]);
      res.near_b_x = 32'(cl[3]);
      res.near_b_y = 32'(cl[4]);
      res.near_b_z = 32'(cl[5]);
      res.status = in_box ? ST_INSIDE : ST_OUTSIDE;
      res.saturated = sat82 || csat;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= res;
    end
  end

endmodule
